@@ src/dvapg_pkg.sv @@
// Shared types, constants and constant tables for the drum voice allocator.
// Used by dvapg_alu, dvapg_ctl and the top level; no dependencies.
package dvapg_pkg;

	// voice pool sizes
	localparam int KICK_COUNT  = 3;
	localparam int SNARE_COUNT = 3;
	localparam int HAT_COUNT   = 4;

	localparam int KICK_W  = (KICK_COUNT > 1) ? $clog2(KICK_COUNT) : 1;
	localparam int KSCAN_W = $clog2(KICK_COUNT + 1);
	localparam int SNARE_W = (SNARE_COUNT > 1) ? $clog2(SNARE_COUNT) : 1;
	localparam int HAT_W   = (HAT_COUNT > 1) ? $clog2(HAT_COUNT) : 1;

	// arithmetic widths
	localparam int OPA_W      = 31;          // multiplier operand a, holds exp(0) in Q30
	localparam int OPB_W      = 16;
	localparam int PROD_W     = OPA_W + OPB_W;
	localparam int QUO_W      = 23;          // x = t/tau in Q20, at most 5.0
	localparam int DIV_FRAC_W = 20;
	localparam int SH_IN_W    = QUO_W - DIV_FRAC_W;
	localparam int REM_W      = 26;          // holds tau*1000 for any 16 bit tau
	localparam int STEP_W     = $clog2(QUO_W);
	localparam int EXP_FRAC_W = 16;          // table step is 1/16
	localparam int EXP_IDX_W  = QUO_W - EXP_FRAC_W;
	localparam int ROUND_SH   = 22;          // Q30 * Hz -> Q16.8 Hz
	localparam int FREQ_W     = 24;

	localparam logic [OPB_W-1:0]  MS_TO_US  = 16'd1000;
	localparam logic [17:0]       LIMIT_MIN = 18'd5;
	localparam logic [FREQ_W-1:0] FREQ_MIN  = 24'd256;
	localparam logic [QUO_W-1:0]  X_MAX     = 23'(5 << DIV_FRAC_W);

	// exp(-i/16) in Q30, i = 0..EXP_LAST
	localparam int EXP_LAST = 80;
	localparam logic [63:0] EXP_STEP = 64'd1008687096;

	typedef logic [EXP_LAST:0][OPA_W-1:0] exp_tab_t;

	function automatic exp_tab_t exp_tab_build();
		exp_tab_t    tab;
		logic [63:0] e;
		int          i;
		e = 64'd1 << 30;
		for (i = 0; i <= EXP_LAST; i++) begin
			tab[i] = e[OPA_W-1:0];
			e = (e * EXP_STEP + (64'd1 << 29)) >> 30;
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = exp_tab_build();

	// volume percent -> Q1.15 amplitude, rounded
	localparam int AMP_FULL_PCT = 100;

	typedef logic [AMP_FULL_PCT:0][15:0] amp_tab_t;

	function automatic amp_tab_t amp_tab_build();
		amp_tab_t tab;
		int       v;
		for (v = 0; v <= AMP_FULL_PCT; v++) begin
			tab[v] = 16'((v * 32768 + 50) / 100);
		end
		return tab;
	endfunction

	localparam amp_tab_t AMP_TAB = amp_tab_build();

	// input modes
	localparam logic [1:0] MODE_KICK  = 2'd0;
	localparam logic [1:0] MODE_SNARE = 2'd1;
	localparam logic [1:0] MODE_HAT   = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	// voice kinds
	localparam logic [1:0] KIND_KICK  = 2'd0;
	localparam logic [1:0] KIND_SNARE = 2'd1;
	localparam logic [1:0] KIND_HAT   = 2'd2;

	// result events
	localparam logic [1:0] EV_ON  = 2'd0;
	localparam logic [1:0] EV_UPD = 2'd1;
	localparam logic [1:0] EV_OFF = 2'd2;

	typedef enum logic [1:0] {
		ALU_NOP,
		ALU_MUL,
		ALU_DLOAD,
		ALU_DSTEP
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [OPA_W-1:0] opa;
		logic [OPB_W-1:0] opb;
	} alu_req_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] param_a;
		logic [15:0] param_b;
		logic [7:0]  volume_pct;
		logic [15:0] elapsed_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        voice_kind;
		logic [1:0]        voice_index;
		logic [1:0]        event_res;
		logic [15:0]       decay_ms;
		logic [15:0]       amplitude;
		logic [FREQ_W-1:0] frequency;
		logic              last;
	} res_item_t;

endpackage

@@ src/drum_voice_allocator_pitch_glide.sv @@
// Top level of the drum voice allocator with kick pitch glide.
// Depends on dvapg_pkg, dvapg_alu and dvapg_ctl.
//
// Usage:
//   s_* carries one item per trigger or time tick. s_tuser is the mode
//   (kick, snare, hat, tick); s_tdata carries the operands.
//   m_* carries result items: one note-on per trigger, and per tick one
//   item for each active kick voice (frequency update or note-off), in
//   voice order. m_tlast marks the final result of an input item; a tick
//   with no active kick voice gives no result.
//   A trigger result is registered in the sequencer and then moved into
//   the output register; the next item is taken once the sequencer is idle.
//   A tick runs, for each gliding kick voice, the 23-step restoring
//   divide (t/tau) in the shared unit plus the multiplies for
//   limit, tau, table interpolation and f0*exp. A note-off goes from the
//   scan through the limit check to the emit state; an idle voice is only scanned.
//   s_tready is high only while the sequencer is idle: one item at a time.
//   Reset clears all voices, round-robin pointers and kick parameters
//   (80 Hz, 120 ms, 300 ms limit). A stalled receiver holds the output
//   register; the sequencer holds its next result and takes a new item only
//   once the last result of the current one is in the output register.
module drum_voice_allocator_pitch_glide import dvapg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// param_a[15:0], param_b[31:16], volume_pct[39:32], elapsed_us[55:40]
	input  logic [55:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// voice_index[1:0], decay_ms[17:2], amplitude[33:18], frequency[57:34], zero fill
	output logic [63:0] m_tdata,
	// voice_kind[1:0], event_res[3:2]
	output logic [3:0]  m_tuser,
	output logic        m_tlast
);

	in_item_t          in_item;
	res_item_t         res;
	res_item_t         out_q;
	logic              out_valid_q;
	logic              res_valid;
	logic              res_ready;
	alu_req_t          alu_req;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo;

	// unpack the input item
	always_comb begin
		in_item.mode       = s_tuser;
		in_item.param_a    = s_tdata[15:0];
		in_item.param_b    = s_tdata[31:16];
		in_item.volume_pct = s_tdata[39:32];
		in_item.elapsed_us = s_tdata[55:40];
	end

	dvapg_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.alu_req   (alu_req),
		.prod      (prod),
		.quo       (quo)
	);

	dvapg_alu u_alu (
		.clk  (clk),
		.req  (alu_req),
		.prod (prod),
		.quo  (quo)
	);

	// output register: refills in the cycle the held item is taken
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, out_q.frequency, out_q.amplitude, out_q.decay_ms,
	                   out_q.voice_index};
	assign m_tuser  = {out_q.event_res, out_q.voice_kind};
	assign m_tlast  = out_q.last;

endmodule

@@ src/dvapg_alu.sv @@
// Shared arithmetic unit: one 31x16 multiplier and one restoring divide step.
// Depends on dvapg_pkg; driven cycle by cycle by dvapg_ctl.
module dvapg_alu import dvapg_pkg::*; (
	input  logic              clk,
	input  alu_req_t          req,
	output logic [PROD_W-1:0] prod,
	output logic [QUO_W-1:0]  quo
);

	logic [PROD_W-1:0] prod_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  sh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    divisor;
	logic [REM_W:0]    diff;
	logic              fits;

	always_comb begin
		trial   = {rem_q, sh_q[QUO_W-1]};
		divisor = {1'b0, req.opa[REM_W-1:0]};
		diff    = trial - divisor;
		fits    = (trial >= divisor);
	end

	always_ff @(posedge clk) begin
		unique case (req.op)
			ALU_MUL: begin
				prod_q <= PROD_W'(req.opa) * PROD_W'(req.opb);
			end
			ALU_DLOAD: begin
				// opa: upper dividend bits, opb: bits still to shift in
				rem_q <= req.opa[REM_W-1:0];
				sh_q  <= {req.opb[SH_IN_W-1:0], {DIV_FRAC_W{1'b0}}};
				quo_q <= '0;
			end
			ALU_DSTEP: begin
				rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
				sh_q  <= sh_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	assign prod = prod_q;
	assign quo  = quo_q;

endmodule

@@ src/dvapg_ctl.sv @@
// Sequencer: voice allocation, kick voice state and the per-voice glide steps.
// Depends on dvapg_pkg; issues work to dvapg_alu and hands results to the top.
module dvapg_ctl import dvapg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              res_valid,
	input  logic              res_ready,
	output res_item_t         res,
	output alu_req_t          alu_req,
	input  logic [PROD_W-1:0] prod,
	input  logic [QUO_W-1:0]  quo
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LIMCHK,
		ST_DLOAD,
		ST_DSTEP,
		ST_INTERP,
		ST_EXP,
		ST_FMUL,
		ST_FREQ,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [KSCAN_W-1:0]  vi_q;
	logic [STEP_W-1:0]   step_q;
	logic [15:0]         el_q;
	logic [31:0]         t_q;
	logic [REM_W-1:0]    tau1k_q;
	logic [OPA_W-1:0]    e_q;
	res_item_t           res_q;

	logic [KICK_COUNT-1:0] kick_active_q;
	logic [31:0]           kick_time_q  [KICK_COUNT];
	logic [15:0]           kick_freq_q  [KICK_COUNT];
	logic [15:0]           kick_tau_q   [KICK_COUNT];
	logic [17:0]           kick_limit_q [KICK_COUNT];
	logic [KICK_W-1:0]     kick_next_q;
	logic [SNARE_W-1:0]    snare_next_q;
	logic [HAT_W-1:0]      hat_next_q;

	logic [KICK_W-1:0]    vidx;
	logic                 vi_in_range;
	logic [15:0]          a1;
	logic [15:0]          b1;
	logic [6:0]           vol_c;
	logic [15:0]          amp;
	logic [17:0]          lim3;
	logic [17:0]          lim;
	logic [32:0]          tsum;
	logic [31:0]          tsat;
	logic                 more_above;
	logic [EXP_IDX_W-1:0] xi;
	logic [EXP_IDX_W-1:0] ia;
	logic [EXP_IDX_W-1:0] ib;
	logic [OPA_W-1:0]     exp_a;
	logic [OPA_W-1:0]     exp_b;
	logic [PROD_W:0]      fsum;
	logic [FREQ_W-1:0]    fr;

	always_comb begin
		vidx        = vi_q[KICK_W-1:0];
		vi_in_range = (vi_q < KSCAN_W'(KICK_COUNT));

		a1    = (in_item.param_a == 16'd0) ? 16'd1 : in_item.param_a;
		b1    = (in_item.param_b == 16'd0) ? 16'd1 : in_item.param_b;
		vol_c = (in_item.volume_pct > 8'(AMP_FULL_PCT)) ? 7'(AMP_FULL_PCT)
		                                               : in_item.volume_pct[6:0];
		amp   = AMP_TAB[vol_c];
		lim3  = {2'b00, b1} + {1'b0, b1, 1'b0};
		lim   = (lim3 < LIMIT_MIN) ? LIMIT_MIN : lim3;

		tsum = 33'(vi_in_range ? kick_time_q[vidx] : 32'd0) + 33'(el_q);
		tsat = tsum[32] ? '1 : tsum[31:0];

		more_above = 1'b0;
		for (int k = 0; k < KICK_COUNT; k++) begin
			if (KSCAN_W'(k) > vi_q && kick_active_q[k]) begin
				more_above = 1'b1;
			end
		end

		// table lookup with clamp at the far end
		xi    = quo[QUO_W-1:EXP_FRAC_W];
		ia    = (xi >= EXP_IDX_W'(EXP_LAST)) ? EXP_IDX_W'(EXP_LAST) : xi;
		ib    = (xi >= EXP_IDX_W'(EXP_LAST)) ? EXP_IDX_W'(EXP_LAST) : xi + 1'b1;
		exp_a = EXP_TAB[ia];
		exp_b = EXP_TAB[ib];

		fsum = (PROD_W + 1)'(prod) + ((PROD_W + 1)'(1) << (ROUND_SH - 1));
		fr   = fsum[ROUND_SH +: FREQ_W];
		if (fr < FREQ_MIN) begin
			fr = FREQ_MIN;
		end
	end

	// operand select for the shared unit
	always_comb begin
		alu_req.op  = ALU_NOP;
		alu_req.opa = '0;
		alu_req.opb = '0;
		unique case (state_q)
			ST_SCAN: begin
				if (vi_in_range) begin
					alu_req.op  = ALU_MUL;
					alu_req.opa = OPA_W'(kick_limit_q[vidx]);
					alu_req.opb = MS_TO_US;
				end
			end
			ST_LIMCHK: begin
				alu_req.op  = ALU_MUL;
				alu_req.opa = OPA_W'(kick_tau_q[vidx]);
				alu_req.opb = MS_TO_US;
			end
			ST_DLOAD: begin
				alu_req.op  = ALU_DLOAD;
				alu_req.opa = OPA_W'(t_q[31:SH_IN_W]);
				alu_req.opb = OPB_W'(t_q[SH_IN_W-1:0]);
			end
			ST_DSTEP: begin
				alu_req.op  = ALU_DSTEP;
				alu_req.opa = OPA_W'(tau1k_q);
			end
			ST_INTERP: begin
				alu_req.op  = ALU_MUL;
				alu_req.opa = exp_a - exp_b;
				alu_req.opb = quo[EXP_FRAC_W-1:0];
			end
			ST_FMUL: begin
				alu_req.op  = ALU_MUL;
				alu_req.opa = e_q;
				alu_req.opb = kick_freq_q[vidx];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			vi_q          <= '0;
			step_q        <= '0;
			el_q          <= '0;
			t_q           <= '0;
			tau1k_q       <= '0;
			e_q           <= '0;
			res_q         <= '0;
			kick_active_q <= '0;
			kick_next_q   <= '0;
			snare_next_q  <= '0;
			hat_next_q    <= '0;
			for (int k = 0; k < KICK_COUNT; k++) begin
				kick_time_q[k]  <= 32'd0;
				kick_freq_q[k]  <= 16'd80;
				kick_tau_q[k]   <= 16'd120;
				kick_limit_q[k] <= 18'd300;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_item.mode)
							MODE_KICK: begin
								kick_active_q[kick_next_q] <= 1'b1;
								kick_time_q[kick_next_q]   <= 32'd0;
								kick_freq_q[kick_next_q]   <= a1;
								kick_tau_q[kick_next_q]    <= b1;
								kick_limit_q[kick_next_q]  <= lim;
								kick_next_q <= (kick_next_q == KICK_W'(KICK_COUNT - 1))
								             ? '0 : kick_next_q + 1'b1;
								res_q <= '{KIND_KICK, 2'(kick_next_q), EV_ON, b1, amp,
								           {a1, 8'h00}, 1'b1};
								state_q <= ST_EMIT;
							end
							MODE_SNARE: begin
								snare_next_q <= (snare_next_q == SNARE_W'(SNARE_COUNT - 1))
								              ? '0 : snare_next_q + 1'b1;
								res_q <= '{KIND_SNARE, 2'(snare_next_q), EV_ON, a1, amp,
								           24'd0, 1'b1};
								state_q <= ST_EMIT;
							end
							MODE_HAT: begin
								hat_next_q <= (hat_next_q == HAT_W'(HAT_COUNT - 1))
								            ? '0 : hat_next_q + 1'b1;
								res_q <= '{KIND_HAT, 2'(hat_next_q), EV_ON, a1, amp,
								           24'd0, 1'b1};
								state_q <= ST_EMIT;
							end
							default: begin
								el_q    <= in_item.elapsed_us;
								vi_q    <= '0;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!vi_in_range) begin
						state_q <= ST_IDLE;
					end else if (kick_active_q[vidx]) begin
						t_q               <= tsat;
						kick_time_q[vidx] <= tsat;
						state_q           <= ST_LIMCHK;
					end else begin
						vi_q <= vi_q + 1'b1;
					end
				end
				ST_LIMCHK: begin
					// prod holds limit*1000
					if (PROD_W'(t_q) > prod) begin
						kick_active_q[vidx] <= 1'b0;
						res_q   <= '{KIND_KICK, 2'(vidx), EV_OFF, 16'd0, 16'd0, 24'd0,
						           !more_above};
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DLOAD;
					end
				end
				ST_DLOAD: begin
					tau1k_q <= prod[REM_W-1:0];
					step_q  <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(QUO_W - 1)) begin
						state_q <= ST_INTERP;
					end
				end
				ST_INTERP: begin
					e_q     <= exp_a;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					e_q     <= e_q - prod[PROD_W-1:EXP_FRAC_W];
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					state_q <= ST_FREQ;
				end
				ST_FREQ: begin
					res_q   <= '{KIND_KICK, 2'(vidx), EV_UPD, 16'd0, 16'd0, fr, !more_above};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_ready) begin
						if (res_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							vi_q    <= vi_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

`ifndef SYNTH
	a_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.event_res == EV_OFF |-> vi_in_range && !kick_active_q[vidx])
		else $error("note-off sent for a voice still active");

	a_freq_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.event_res == EV_UPD |-> res_q.frequency >= FREQ_MIN)
		else $error("glide frequency below floor");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INTERP |-> quo <= X_MAX)
		else $error("t/tau beyond table range");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.mode == MODE_TICK |=> state_q == ST_SCAN && vi_q == '0)
		else $error("tick did not start scan at voice zero");
`endif

endmodule
